/* design/adts_frame_deframer_core_assert.svh */
// ----------------------------------------------------------------------------
// ADTS deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADTS_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define ADTS_FRAME_DEFRAMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ADTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/adts_pkg.sv */
// ----------------------------------------------------------------------------
// ADTS deframer package
// Request types, status codes, parser phases and the sampling rate table.
// ----------------------------------------------------------------------------
package adts_pkg;

    localparam logic [11:0] SYNC_WORD    = 12'hFFF;
    localparam logic [12:0] HDR_LEN_NOCRC = 13'd7;
    localparam logic [12:0] HDR_LEN_CRC   = 13'd9;
    localparam logic [2:0]  HDR_BYTES     = 3'd7;
    localparam logic [2:0]  CRC_BYTES     = 3'd2;
    localparam logic [4:0]  AOT_AAC_LC    = 5'd2;

    localparam logic [2:0] STATUS_PAYLOAD   = 3'd0;
    localparam logic [2:0] STATUS_HEADER    = 3'd1;
    localparam logic [2:0] STATUS_FORMAT    = 3'd2;
    localparam logic [2:0] STATUS_CLEAN_END = 3'd3;
    localparam logic [2:0] STATUS_PREMATURE = 3'd4;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_CRC,
        PH_PAY,
        PH_HALT
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } adts_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [16:0] sample_rate_hz;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic [12:0] payload_length;
        logic        crc_present;
        logic [31:0] frame_number;
        logic [15:0] decoder_config;
    } adts_out_t;

    // A zero entry marks an unsupported sampling frequency index.
    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

endpackage

/* design/adts_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// ADTS frame deframer core
// Parses back-to-back ADTS frames from a byte stream, reports one header
// request per frame and passes the payload bytes through.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Direction
//  stream    stream_valid, stream_stall, stream_item  byte in
//  result    result_valid, result_stall, result_item  result out
//
// One byte is accepted per cycle while stream_stall is low; each request
// passes from the state registers through the header decode into the
// registered result. The result register lets a new byte enter while the
// previous result is taken in the same cycle; stream_stall rises only
// while a held result is itself stalled. Reset puts the parser in header
// gathering with no frames counted. After a format error or an end of
// input the block drops every further byte until reset.

module adts_frame_deframer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stream_valid,
    output logic              stream_stall,
    input  adts_pkg::adts_in_t  stream_item,
    output logic              result_valid,
    input  logic              result_stall,
    output adts_pkg::adts_out_t result_item
);

    `include "adts_frame_deframer_core_assert.svh"

    adts_pkg::phase_t phase_reg, phase_next;
    logic [47:0] hdr_shift_reg, hdr_shift_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [12:0] payload_left_reg, payload_left_next;
    logic [31:0] frame_counter_reg, frame_counter_next;
    logic        crc_flag_reg, crc_flag_next;

    logic                result_valid_reg;
    adts_pkg::adts_out_t result_reg;

    logic                accept;
    logic                res_fire;
    adts_pkg::adts_out_t res;

    // Header fields as seen on the seventh header byte.
    logic [55:0] hdr_word;
    logic [11:0] hdr_sync;
    logic        hdr_id;
    logic [1:0]  hdr_layer;
    logic        hdr_prot_absent;
    logic [3:0]  hdr_ridx;
    logic [2:0]  hdr_chan;
    logic [12:0] hdr_flen;
    logic [12:0] hdr_len;
    logic [16:0] hdr_hz;
    logic [12:0] hdr_pay_len;
    logic        hdr_ok;
    logic        hdr_last;

    logic        held_terminal;
    logic        held_last;

    assign stream_stall = result_valid_reg && result_stall;
    assign accept       = stream_valid && !stream_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    assign hdr_word        = {hdr_shift_reg, stream_item.in_byte};
    assign hdr_sync        = hdr_word[55:44];
    assign hdr_id          = hdr_word[43];
    assign hdr_layer       = hdr_word[42:41];
    assign hdr_prot_absent = hdr_word[40];
    assign hdr_ridx        = hdr_word[37:34];
    assign hdr_chan        = hdr_word[32:30];
    assign hdr_flen        = hdr_word[25:13];
    assign hdr_len         = hdr_prot_absent ? adts_pkg::HDR_LEN_NOCRC
                                             : adts_pkg::HDR_LEN_CRC;
    assign hdr_hz          = adts_pkg::rate_hz(hdr_ridx);
    assign hdr_pay_len     = hdr_flen - hdr_len;
    assign hdr_ok          = (hdr_sync == adts_pkg::SYNC_WORD) && !hdr_id
                             && (hdr_layer == 2'd0) && (hdr_hz != 17'd0)
                             && (hdr_flen >= hdr_len);
    assign hdr_last        = (byte_count_reg == adts_pkg::HDR_BYTES - 3'd1);

    // Next state of the parser for the byte being accepted.
    always_comb
    begin
        phase_next         = phase_reg;
        hdr_shift_next     = hdr_shift_reg;
        byte_count_next    = byte_count_reg;
        payload_left_next  = payload_left_reg;
        frame_counter_next = frame_counter_reg;
        crc_flag_next      = crc_flag_reg;
        if (accept && phase_reg != adts_pkg::PH_HALT)
        begin
            if (stream_item.end_of_input)
            begin
                phase_next = adts_pkg::PH_HALT;
            end
            else
            begin
                case (phase_reg)
                    adts_pkg::PH_HDR:
                    begin
                        hdr_shift_next = hdr_word[47:0];
                        if (!hdr_last)
                        begin
                            byte_count_next = byte_count_reg + 3'd1;
                        end
                        else
                        begin
                            byte_count_next = 3'd0;
                            if (!hdr_ok)
                            begin
                                phase_next = adts_pkg::PH_HALT;
                            end
                            else
                            begin
                                crc_flag_next      = !hdr_prot_absent;
                                payload_left_next  = hdr_pay_len;
                                frame_counter_next = frame_counter_reg + 32'd1;
                                if (!hdr_prot_absent)
                                    phase_next = adts_pkg::PH_CRC;
                                else if (hdr_pay_len != 13'd0)
                                    phase_next = adts_pkg::PH_PAY;
                                else
                                    phase_next = adts_pkg::PH_HDR;
                            end
                        end
                    end
                    adts_pkg::PH_CRC:
                    begin
                        if (byte_count_reg == adts_pkg::CRC_BYTES - 3'd1)
                        begin
                            byte_count_next = 3'd0;
                            phase_next = (payload_left_reg != 13'd0) ? adts_pkg::PH_PAY
                                                                      : adts_pkg::PH_HDR;
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + 3'd1;
                        end
                    end
                    adts_pkg::PH_PAY:
                    begin
                        payload_left_next = payload_left_reg - 13'd1;
                        if (payload_left_reg == 13'd1)
                            phase_next = adts_pkg::PH_HDR;
                    end
                    default:
                    begin
                        phase_next = adts_pkg::PH_HALT;
                    end
                endcase
            end
        end
    end

    // Result for the byte being accepted; fields not used by a status stay zero.
    always_comb
    begin
        res      = '0;
        res_fire = 1'b0;
        if (phase_reg != adts_pkg::PH_HALT)
        begin
            if (stream_item.end_of_input)
            begin
                res_fire   = 1'b1;
                res.status = (phase_reg == adts_pkg::PH_HDR && byte_count_reg == 3'd0)
                             ? adts_pkg::STATUS_CLEAN_END : adts_pkg::STATUS_PREMATURE;
            end
            else
            begin
                case (phase_reg)
                    adts_pkg::PH_HDR:
                    begin
                        if (hdr_last)
                        begin
                            res_fire = 1'b1;
                            if (!hdr_ok)
                            begin
                                res.status = adts_pkg::STATUS_FORMAT;
                            end
                            else
                            begin
                                res.status         = adts_pkg::STATUS_HEADER;
                                res.sample_rate_hz = hdr_hz;
                                res.rate_index     = hdr_ridx;
                                res.channel_config = hdr_chan;
                                res.payload_length = hdr_pay_len;
                                res.crc_present    = !hdr_prot_absent;
                                res.frame_number   = frame_counter_reg;
                                res.decoder_config = {adts_pkg::AOT_AAC_LC, hdr_ridx, 1'b0,
                                                      hdr_chan, 3'b000};
                            end
                        end
                    end
                    adts_pkg::PH_PAY:
                    begin
                        res_fire          = 1'b1;
                        res.status        = adts_pkg::STATUS_PAYLOAD;
                        res.payload_byte  = stream_item.in_byte;
                        res.last_of_frame = (payload_left_reg == 13'd1);
                    end
                    default:
                    begin
                        res_fire = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= adts_pkg::PH_HDR;
            hdr_shift_reg     <= '0;
            byte_count_reg    <= '0;
            payload_left_reg  <= '0;
            frame_counter_reg <= '0;
            crc_flag_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            hdr_shift_reg     <= hdr_shift_next;
            byte_count_reg    <= byte_count_next;
            payload_left_reg  <= payload_left_next;
            frame_counter_reg <= frame_counter_next;
            crc_flag_reg      <= crc_flag_next;
            if (accept)
                result_valid_reg <= res_fire;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= res;
    end

    assign held_terminal = result_valid_reg
                           && (result_reg.status inside {adts_pkg::STATUS_FORMAT,
                                                         adts_pkg::STATUS_CLEAN_END,
                                                         adts_pkg::STATUS_PREMATURE});
    assign held_last     = result_valid_reg && result_reg.status == adts_pkg::STATUS_PAYLOAD
                           && result_reg.last_of_frame;

    // Once halted, accepted bytes produce nothing.
    `ADTS_ASSERT_NEXT(a_halt_silent, accept && phase_reg == adts_pkg::PH_HALT, !result_valid_reg)

    // Payload phase is entered only with bytes left to pass.
    `ADTS_ASSERT_SAME(a_pay_nonzero, phase_reg == adts_pkg::PH_PAY, payload_left_reg != 13'd0)

    // A held terminal status means the parser has halted.
    `ADTS_ASSERT_SAME(a_term_halted, held_terminal, phase_reg == adts_pkg::PH_HALT)

    // After the last payload byte the next header starts from its first byte.
    `ADTS_ASSERT_SAME(a_last_rearm, held_last, phase_reg == adts_pkg::PH_HDR && byte_count_reg == 3'd0)

endmodule
